[design/rvp_pkg.sv]
package rvp_pkg;

	// frame limits
	localparam int MAX_PAYLOAD = 1400;
	localparam int MAX_FRAME   = 1048576;

	// field widths
	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 2;
	localparam int LEN_W   = 21;
	localparam int CHUNK_W = 11;
	localparam int SEQ_W   = 16;
	localparam int TS_W    = 32;
	localparam int RATE_W  = 8;
	localparam int SSRC_W  = 32;
	localparam int STEP_W  = 17;
	localparam int POS_W   = 5;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// frame kinds
	localparam logic [KIND_W-1:0] KIND_I = 2'd0;
	localparam logic [KIND_W-1:0] KIND_P = 2'd1;

	// register indexes
	localparam logic [1:0] REG_UDP_MODE   = 2'd0;
	localparam logic [1:0] REG_FRAME_RATE = 2'd1;
	localparam logic [1:0] REG_SSRC       = 2'd2;

	// header constants
	localparam logic [BYTE_W-1:0] PAYLOAD_TYPE = 8'd96;
	localparam logic [BYTE_W-1:0] VER_PLAIN    = 8'h80;
	localparam logic [BYTE_W-1:0] VER_STREAM   = 8'h90;
	localparam logic [SEQ_W-1:0]  SEQ_WRAP     = 16'hFFFF;
	localparam logic [15:0]       STREAM_EXTRA = 16'd20;
	localparam logic [RATE_W-1:0] DEFAULT_RATE = 8'd25;
	localparam logic [RATE_W-1:0] RATE_LIMIT   = 8'd30;

	// byte positions within a packet; plain mode starts at the version byte
	// and jumps from the last ssrc byte to the payload
	localparam logic [POS_W-1:0] POS_LEN_HI  = 5'd0;
	localparam logic [POS_W-1:0] POS_LEN_LO  = 5'd1;
	localparam logic [POS_W-1:0] POS_VER     = 5'd2;
	localparam logic [POS_W-1:0] POS_PT      = 5'd3;
	localparam logic [POS_W-1:0] POS_SEQ_HI  = 5'd4;
	localparam logic [POS_W-1:0] POS_SEQ_LO  = 5'd5;
	localparam logic [POS_W-1:0] POS_TS_0    = 5'd6;
	localparam logic [POS_W-1:0] POS_TS_1    = 5'd7;
	localparam logic [POS_W-1:0] POS_TS_2    = 5'd8;
	localparam logic [POS_W-1:0] POS_TS_3    = 5'd9;
	localparam logic [POS_W-1:0] POS_SSRC_0  = 5'd10;
	localparam logic [POS_W-1:0] POS_SSRC_1  = 5'd11;
	localparam logic [POS_W-1:0] POS_SSRC_2  = 5'd12;
	localparam logic [POS_W-1:0] POS_SSRC_3  = 5'd13;
	localparam logic [POS_W-1:0] POS_EXT_1   = 5'd15;
	localparam logic [POS_W-1:0] POS_EXT_3   = 5'd17;
	localparam logic [POS_W-1:0] POS_EXT_KND = 5'd21;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd22;

	// timestamp step per frame rate 1..29
	localparam logic [STEP_W-1:0] STEP_TABLE [29] = '{
		17'd90000, 17'd45000, 17'd30000, 17'd22500, 17'd18000, 17'd15000,
		17'd12857, 17'd11250, 17'd10000, 17'd9000, 17'd8181, 17'd7500,
		17'd6923, 17'd6428, 17'd6000, 17'd5625, 17'd5294, 17'd5000,
		17'd4736, 17'd4500, 17'd4285, 17'd4090, 17'd3913, 17'd3750,
		17'd3600, 17'd3461, 17'd3333, 17'd3214, 17'd3103
	};

	typedef struct packed {
		logic              udp_mode;
		logic [RATE_W-1:0] frame_rate;
		logic [SSRC_W-1:0] ssrc_value;
	} cfg_t;

	// one accepted byte and the header that goes before it
	typedef struct packed {
		logic              hdr;
		logic              udp;
		logic              marker;
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  seq;
		logic [TS_W-1:0]   ts;
		logic [SSRC_W-1:0] ssrc;
		logic [15:0]       plen;
		logic [BYTE_W-1:0] data;
		logic              pend;
	} job_t;

	function automatic logic [STEP_W-1:0] time_step(input logic [RATE_W-1:0] rate);
		logic [4:0] idx;
		if (rate == '0 || rate >= RATE_LIMIT)
			idx = 5'(DEFAULT_RATE - 8'd1);
		else
			idx = 5'(rate - 8'd1);
		return STEP_TABLE[idx];
	endfunction

endpackage

[design/rvp_byte_if.sv]
interface rvp_byte_if;
	import rvp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              frame_start;
	logic [KIND_W-1:0] frame_kind;
	logic [LEN_W-1:0]  frame_length;

	modport source(output valid, data_byte, frame_start, frame_kind, frame_length,
		input ready);
	modport sink(input valid, data_byte, frame_start, frame_kind, frame_length,
		output ready);
endinterface

[design/rvp_pkt_if.sv]
interface rvp_pkt_if;
	import rvp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              packet_end;
	logic              run_last;

	modport source(output valid, out_byte, packet_end, run_last, input ready);
	modport sink(input valid, out_byte, packet_end, run_last, output ready);
endinterface

[design/rvp_cfg_regs.sv]
module rvp_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rvp_pkg::ADDR_W-1:0] paddr,
	input  logic [rvp_pkg::DATA_W-1:0] pwdata,
	output logic [rvp_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rvp_pkg::cfg_t              cfg
);
	import rvp_pkg::*;

	logic              udp_mode_q;
	logic [RATE_W-1:0] frame_rate_q;
	logic [SSRC_W-1:0] ssrc_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			udp_mode_q   <= 1'b1;
			frame_rate_q <= DEFAULT_RATE;
			ssrc_q       <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_UDP_MODE:   udp_mode_q   <= pwdata[0];
				REG_FRAME_RATE: frame_rate_q <= pwdata[RATE_W-1:0];
				REG_SSRC:       ssrc_q       <= pwdata[SSRC_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[3:2])
			REG_UDP_MODE:   prdata = DATA_W'(udp_mode_q);
			REG_FRAME_RATE: prdata = DATA_W'(frame_rate_q);
			REG_SSRC:       prdata = ssrc_q;
			default:        prdata = '0;
		endcase
	end

	assign cfg = '{udp_mode: udp_mode_q, frame_rate: frame_rate_q, ssrc_value: ssrc_q};
endmodule

[design/rvp_frame_ctrl.sv]
module rvp_frame_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [rvp_pkg::BYTE_W-1:0] data_byte,
	input  logic                       frame_start,
	input  logic [rvp_pkg::KIND_W-1:0] frame_kind,
	input  logic [rvp_pkg::LEN_W-1:0]  frame_length,
	input  rvp_pkg::cfg_t              cfg,
	output rvp_pkg::job_t              job,
	output logic                       job_valid
);
	import rvp_pkg::*;

	logic [SEQ_W-1:0]   seq_q;
	logic [TS_W-1:0]    ts_q;
	logic               key_seen_q;
	logic               frame_open_q;
	logic [LEN_W-1:0]   frame_left_q;
	logic [CHUNK_W-1:0] chunk_left_q;
	logic [KIND_W-1:0]  kind_q;

	logic               drop;
	logic               e_key;
	logic               e_open;
	logic [LEN_W-1:0]   e_fleft;
	logic [CHUNK_W-1:0] e_cleft;
	logic [KIND_W-1:0]  e_kind;
	logic               busy;
	logic               hdr;
	logic               marker;
	logic [CHUNK_W-1:0] clen;
	logic [SEQ_W-1:0]   seq_inc;
	logic [SEQ_W-1:0]   seq_new;
	logic [CHUNK_W-1:0] n_cleft;
	logic [LEN_W-1:0]   n_fleft;
	logic               frame_done;

	// frame start handling
	always_comb begin
		drop    = 1'b0;
		e_key   = key_seen_q;
		e_open  = frame_open_q;
		e_fleft = frame_left_q;
		e_cleft = chunk_left_q;
		e_kind  = kind_q;
		if (frame_start) begin
			if (frame_length == '0 || frame_length > LEN_W'(MAX_FRAME)) begin
				drop = 1'b1;
			end else begin
				e_open  = 1'b0;
				e_fleft = '0;
				e_cleft = '0;
				if (frame_kind == KIND_I)
					e_key = 1'b1;
				if (e_key && (frame_kind == KIND_I || frame_kind == KIND_P)) begin
					e_open  = 1'b1;
					e_fleft = frame_length;
					e_kind  = frame_kind;
				end
			end
		end
	end

	// chunking and header decision
	always_comb begin
		busy       = !drop && e_open && (e_fleft != '0);
		hdr        = (e_cleft == '0);
		marker     = (e_fleft <= LEN_W'(MAX_PAYLOAD));
		clen       = hdr ? (marker ? CHUNK_W'(e_fleft) : CHUNK_W'(MAX_PAYLOAD)) : e_cleft;
		seq_inc    = seq_q + 16'd1;
		seq_new    = (seq_inc == SEQ_WRAP) ? '0 : seq_inc;
		n_cleft    = clen - 11'd1;
		n_fleft    = e_fleft - 21'd1;
		frame_done = (n_fleft == '0);
	end

	assign job_valid = busy;
	assign job = '{
		hdr:    hdr,
		udp:    cfg.udp_mode,
		marker: marker,
		kind:   e_kind,
		seq:    seq_new,
		ts:     ts_q,
		ssrc:   cfg.ssrc_value,
		plen:   STREAM_EXTRA + 16'(clen),
		data:   data_byte,
		pend:   (n_cleft == '0)
	};

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= '0;
			ts_q         <= '0;
			key_seen_q   <= 1'b0;
			frame_open_q <= 1'b0;
			frame_left_q <= '0;
			chunk_left_q <= '0;
			kind_q       <= '0;
		end else if (accept && !drop) begin
			key_seen_q <= e_key;
			kind_q     <= e_kind;
			if (busy) begin
				frame_open_q <= !frame_done;
				frame_left_q <= n_fleft;
				chunk_left_q <= frame_done ? '0 : n_cleft;
				if (hdr)
					seq_q <= seq_new;
				if (frame_done)
					ts_q <= ts_q + TS_W'(time_step(cfg.frame_rate));
			end else begin
				frame_open_q <= e_open;
				frame_left_q <= e_fleft;
				chunk_left_q <= e_cleft;
			end
		end
	end
endmodule

[design/rvp_emitter.sv]
module rvp_emitter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  rvp_pkg::job_t job,
	output logic          job_free,
	rvp_pkt_if.source     pkt
);
	import rvp_pkg::*;

	job_t              job_s1;
	logic              job_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_end_q;
	logic              out_last_q;

	logic              emit;
	logic              at_payload;
	logic [BYTE_W-1:0] sel_byte;
	logic [POS_W-1:0]  pos_next;

	assign emit       = job_valid_q && (!out_valid_q || pkt.ready);
	assign at_payload = (pos_q == POS_PAYLOAD);
	assign job_free   = !job_valid_q || (emit && at_payload);
	assign pos_next   = (job_s1.udp && pos_q == POS_SSRC_3) ? POS_PAYLOAD : pos_q + 5'd1;

	// byte at the current position
	always_comb begin
		case (pos_q)
			POS_LEN_HI:  sel_byte = job_s1.plen[15:8];
			POS_LEN_LO:  sel_byte = job_s1.plen[7:0];
			POS_VER:     sel_byte = job_s1.udp ? VER_PLAIN : VER_STREAM;
			POS_PT:      sel_byte = {job_s1.marker, PAYLOAD_TYPE[6:0]};
			POS_SEQ_HI:  sel_byte = job_s1.seq[15:8];
			POS_SEQ_LO:  sel_byte = job_s1.seq[7:0];
			POS_TS_0:    sel_byte = job_s1.ts[31:24];
			POS_TS_1:    sel_byte = job_s1.ts[23:16];
			POS_TS_2:    sel_byte = job_s1.ts[15:8];
			POS_TS_3:    sel_byte = job_s1.ts[7:0];
			POS_SSRC_0:  sel_byte = job_s1.ssrc[31:24];
			POS_SSRC_1:  sel_byte = job_s1.ssrc[23:16];
			POS_SSRC_2:  sel_byte = job_s1.ssrc[15:8];
			POS_SSRC_3:  sel_byte = job_s1.ssrc[7:0];
			POS_EXT_1,
			POS_EXT_3:   sel_byte = 8'h01;
			POS_EXT_KND: sel_byte = {2'b00, job_s1.kind, 3'b000, job_s1.marker};
			POS_PAYLOAD: sel_byte = job_s1.data;
			default:     sel_byte = 8'h00;
		endcase
	end

	// job register and position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			pos_q       <= POS_PAYLOAD;
		end else if (load) begin
			job_valid_q <= 1'b1;
			if (!job.hdr)
				pos_q <= POS_PAYLOAD;
			else if (job.udp)
				pos_q <= POS_VER;
			else
				pos_q <= POS_LEN_HI;
		end else if (emit) begin
			if (at_payload)
				job_valid_q <= 1'b0;
			else
				pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			job_s1 <= job;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || pkt.ready)
			out_valid_q <= job_valid_q;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= sel_byte;
			out_end_q  <= at_payload && job_s1.pend;
			out_last_q <= at_payload;
		end
	end

	assign pkt.valid      = out_valid_q;
	assign pkt.out_byte   = out_byte_q;
	assign pkt.packet_end = out_end_q;
	assign pkt.run_last   = out_last_q;
endmodule

[design/rtp_video_packetizer.sv]
// channel       dir   transfer                           contents
// frame_bytes   in    valid & ready at rising edge       payload byte, frame start/kind/length
// pkt_bytes     out   valid & ready at rising edge       packet byte, packet_end, run_last
// apb           cfg   psel & penable & pwrite & pready   udp_mode, frame_rate, ssrc_value
//
// a payload byte inside a chunk goes out as one packet byte; the first byte of a chunk
// goes out after its header, 12 header bytes in plain mode and 22 in stream mode,
// all through the single output byte register
// dropped bytes are taken with no output
// arst_n clears counters and frame state; registers return to their reset values
// frame_bytes stalls while header bytes of the held byte are going out and while
// pkt_bytes holds off a full output register
module rtp_video_packetizer (
	input  logic                       clk,
	input  logic                       arst_n,
	rvp_byte_if.sink                   frame_bytes,
	rvp_pkt_if.source                  pkt_bytes,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rvp_pkg::ADDR_W-1:0] paddr,
	input  logic [rvp_pkg::DATA_W-1:0] pwdata,
	output logic [rvp_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import rvp_pkg::*;

	cfg_t cfg;
	job_t job;
	logic job_valid;
	logic job_free;
	logic accept;

	assign frame_bytes.ready = job_free;
	assign accept            = frame_bytes.valid && frame_bytes.ready;

	// configuration registers
	rvp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// frame tracking and header decision
	rvp_frame_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (frame_bytes.data_byte),
		.frame_start  (frame_bytes.frame_start),
		.frame_kind   (frame_bytes.frame_kind),
		.frame_length (frame_bytes.frame_length),
		.cfg          (cfg),
		.job          (job),
		.job_valid    (job_valid)
	);

	// header and payload serialiser
	rvp_emitter u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && job_valid),
		.job      (job),
		.job_free (job_free),
		.pkt      (pkt_bytes)
	);

`ifndef SYNTHESIS
	// end of packet is always the payload byte closing a run
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_bytes.valid && pkt_bytes.packet_end |-> pkt_bytes.run_last)
		else $error("packet_end without run_last");

	// header bytes follow each other without a gap
	a_hdr_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_bytes.valid && pkt_bytes.ready && !pkt_bytes.run_last |=> pkt_bytes.valid)
		else $error("gap inside a header");

	// no new byte taken while a header is still being sent
	a_hold_in_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_bytes.valid && !pkt_bytes.ready && !pkt_bytes.run_last |-> !frame_bytes.ready)
		else $error("input taken during header");
`endif
endmodule

[sim/tb_top.sv]
module tb_top;
	import rvp_pkg::*;

	localparam int          TYPED_W      = 13 * BYTE_W;
	localparam int          PREDICTED    = -1;
	localparam int          DIR_ROWS     = 24;
	localparam int          DIR_SPLIT    = 19;
	localparam int          PHASES       = 6;
	localparam int          PHASE_ITEMS  = 16;
	localparam int          LEAD_BYTES   = 4;
	localparam int          SETTLE       = 40;
	localparam int          MAX_REPORTS  = 10;
	localparam int unsigned TICKS_PER_S  = 90000;
	localparam int unsigned LEN_TOP      = (1 << LEN_W) - 1;
	localparam logic [KIND_W-1:0] KIND_B     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              start;
		logic [KIND_W-1:0] kind;
		logic [LEN_W-1:0]  len;
	} frame_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] octet;
		logic              pend;
		logic              last;
	} pkt_beat_t;

	typedef struct {
		frame_beat_t        beat;
		int                 n_typed;
		logic [TYPED_W-1:0] typed;
	} dir_row_t;

	// first packet after reset: plain header, marker, sequence 1, zero timestamp and ssrc
	localparam logic [TYPED_W-1:0] FIRST_PACKET = 104'h80_E0_0001_00000000_00000000_FF;

	localparam cfg_t STREAM_EXTREMES = '{udp_mode: 1'b0, frame_rate: 8'd0,
		ssrc_value: 32'hFFFF_FFFF};

	dir_row_t dir_rows [DIR_ROWS] = '{
		// reset settings: stray byte, frames ahead of the first key frame, bad lengths
		'{'{8'h5A, 1'b0, KIND_I, 21'd0}, 0, '0},
		'{'{8'h33, 1'b1, KIND_P, 21'd3}, 0, '0},
		'{'{8'hA5, 1'b0, KIND_P, 21'd3}, 0, '0},
		'{'{8'h00, 1'b1, KIND_I, 21'd0}, 0, '0},
		'{'{8'h44, 1'b1, KIND_P, 21'd2}, 0, '0},
		'{'{8'h12, 1'b1, KIND_I, 21'd1048577}, 0, '0},
		// first key frame of one byte
		'{'{8'hFF, 1'b1, KIND_I, 21'd1}, 13, FIRST_PACKET},
		// b and other frames are dropped
		'{'{8'h00, 1'b1, KIND_B, 21'd2}, 0, '0},
		'{'{8'h11, 1'b0, KIND_B, 21'd2}, 0, '0},
		'{'{8'h22, 1'b1, KIND_OTHER, 21'd1}, 0, '0},
		// short p frame
		'{'{8'h00, 1'b1, KIND_P, 21'd3}, PREDICTED, '0},
		'{'{8'h80, 1'b0, KIND_P, 21'd0}, PREDICTED, '0},
		'{'{8'h7F, 1'b0, KIND_P, 21'd0}, PREDICTED, '0},
		// largest frame cut short by a p frame, itself cut short by an i frame
		'{'{8'h01, 1'b1, KIND_I, 21'd1048576}, PREDICTED, '0},
		'{'{8'hFE, 1'b0, KIND_I, 21'd0}, PREDICTED, '0},
		'{'{8'h3C, 1'b1, KIND_P, 21'd4}, PREDICTED, '0},
		'{'{8'hC3, 1'b0, KIND_P, 21'd0}, PREDICTED, '0},
		'{'{8'h00, 1'b1, KIND_I, 21'd2}, PREDICTED, '0},
		'{'{8'hFF, 1'b0, KIND_I, 21'd0}, PREDICTED, '0},
		// stream mode, rate 0, all-ones ssrc
		'{'{8'h96, 1'b1, KIND_I, 21'h1FFFFF}, 0, '0},
		'{'{8'hAA, 1'b1, KIND_I, 21'd2}, PREDICTED, '0},
		'{'{8'h55, 1'b0, KIND_I, 21'd0}, PREDICTED, '0},
		'{'{8'h0F, 1'b1, KIND_P, 21'd1}, PREDICTED, '0},
		'{'{8'hF0, 1'b1, KIND_B, 21'd1}, 0, '0}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	rvp_byte_if frame_if ();
	rvp_pkt_if  packet_if ();

	rtp_video_packetizer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_bytes (frame_if),
		.pkt_bytes   (packet_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// register shadow and packetizer state
	cfg_t              cfg_live = '{udp_mode: 1'b1, frame_rate: DEFAULT_RATE, ssrc_value: '0};
	logic [SEQ_W-1:0]  seq_count  = '0;
	logic [TS_W-1:0]   ts_count   = '0;
	logic              key_seen   = 1'b0;
	logic              in_frame   = 1'b0;
	logic [LEN_W-1:0]  frame_left = '0;
	logic [CHUNK_W-1:0] chunk_left = '0;
	logic [KIND_W-1:0] cur_kind   = '0;

	pkt_beat_t step_bytes [$];
	pkt_beat_t due_bytes [$];
	int unsigned mismatch_count = 0;
	bit          feed_calm = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// timestamp advance per frame
	function automatic logic [TS_W-1:0] ts_increment(logic [RATE_W-1:0] rate);
		int unsigned r;
		r = (rate == '0 || rate >= RATE_LIMIT) ? DEFAULT_RATE : rate;
		return TS_W'(TICKS_PER_S / r);
	endfunction

	function automatic void emit_octet(logic [BYTE_W-1:0] v, logic pend);
		pkt_beat_t beat;
		beat       = '{octet: v, pend: pend, last: 1'b0};
		step_bytes = {step_bytes, beat};
	endfunction

	function automatic void emit16(logic [15:0] v);
		emit_octet(v[15:8], 1'b0);
		emit_octet(v[7:0], 1'b0);
	endfunction

	function automatic void emit32(logic [31:0] v);
		emit16(v[31:16]);
		emit16(v[15:0]);
	endfunction

	// packet bytes caused by one payload byte
	function automatic void packetize_byte(frame_beat_t b);
		logic marker;
		step_bytes.delete();
		if (b.start) begin
			if (b.len == '0 || b.len > MAX_FRAME)
				return;
			in_frame   = 1'b0;
			frame_left = '0;
			chunk_left = '0;
			if (b.kind == KIND_I)
				key_seen = 1'b1;
			if (!key_seen || b.kind > KIND_P)
				return;
			in_frame   = 1'b1;
			frame_left = b.len;
			cur_kind   = b.kind;
		end
		if (!in_frame || frame_left == '0)
			return;

		// header ahead of each chunk
		if (chunk_left == '0) begin
			marker     = (frame_left <= MAX_PAYLOAD);
			chunk_left = marker ? frame_left[CHUNK_W-1:0] : CHUNK_W'(MAX_PAYLOAD);
			seq_count  = seq_count + 1'b1;
			if (seq_count == SEQ_WRAP)
				seq_count = '0;
			if (cfg_live.udp_mode) begin
				emit_octet(VER_PLAIN, 1'b0);
			end else begin
				emit16(STREAM_EXTRA + 16'(chunk_left));
				emit_octet(VER_STREAM, 1'b0);
			end
			emit_octet({marker, PAYLOAD_TYPE[6:0]}, 1'b0);
			emit16(seq_count);
			emit32(ts_count);
			emit32(cfg_live.ssrc_value);
			if (!cfg_live.udp_mode) begin
				emit32(32'h0001_0001);
				emit16(16'h0000);
				emit_octet(8'h00, 1'b0);
				emit_octet({2'b00, cur_kind, 3'b000, marker}, 1'b0);
			end
		end

		chunk_left = chunk_left - 1'b1;
		frame_left = frame_left - 1'b1;
		emit_octet(b.data, chunk_left == '0);
		if (frame_left == '0) begin
			in_frame   = 1'b0;
			chunk_left = '0;
			ts_count   = ts_count + ts_increment(cfg_live.frame_rate);
		end
		step_bytes[$].last = 1'b1;
	endfunction

	function automatic void log_mismatch(string what, pkt_beat_t want, pkt_beat_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at %0t, %s: want %02h/%0b/%0b got %02h/%0b/%0b", $time, what,
				want.octet, want.pend, want.last, got.octet, got.pend, got.last);
	endfunction

	// one payload byte transfer with a random lead-in gap
	task automatic send_byte(frame_beat_t b, int n_typed, logic [TYPED_W-1:0] typed);
		int unsigned gap;
		int          i;
		pkt_beat_t   beat;
		if ($urandom_range(0, 39) == 0)
			feed_calm = !feed_calm;
		gap = feed_calm ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			frame_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_if.valid        <= 1'b1;
		frame_if.data_byte    <= b.data;
		frame_if.frame_start  <= b.start;
		frame_if.frame_kind   <= b.kind;
		frame_if.frame_length <= b.len;
		@(posedge clk);
		while (!frame_if.ready) @(posedge clk);
		packetize_byte(b);
		if (n_typed == PREDICTED) begin
			due_bytes = {due_bytes, step_bytes};
		end else begin
			for (i = 0; i < n_typed; i++) begin
				beat      = '{octet: typed[BYTE_W*(n_typed-1-i) +: BYTE_W],
					pend: i == n_typed - 1, last: i == n_typed - 1};
				due_bytes = {due_bytes, beat};
			end
		end
	endtask

	// a run of bytes, optionally opening a frame
	task automatic send_frame(bit with_start, logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len,
			int unsigned count);
		frame_beat_t b;
		int unsigned i;
		for (i = 0; i < count; i++) begin
			b.data  = BYTE_W'($urandom);
			b.start = with_start && i == 0;
			b.kind  = b.start ? kind : KIND_W'($urandom);
			b.len   = b.start ? len : LEN_W'($urandom);
			send_byte(b, PREDICTED, '0);
		end
	endtask

	// hold off until every packet byte is out, then let the block settle
	task automatic wait_drain();
		frame_if.valid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// setup and access cycle, select left high for the next write
	task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_UDP_MODE:   cfg_live.udp_mode   = val[0];
			REG_FRAME_RATE: cfg_live.frame_rate = val[RATE_W-1:0];
			REG_SSRC:       cfg_live.ssrc_value = val;
			default: ;
		endcase
	endtask

	task automatic set_config(cfg_t c);
		apb_write(REG_UDP_MODE, DATA_W'(c.udp_mode));
		apb_write(REG_FRAME_RATE, DATA_W'(c.frame_rate));
		apb_write(REG_SSRC, c.ssrc_value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// packet side back-pressure
	initial begin : packet_sink
		int unsigned hold;
		bit          calm;
		calm = 1'b0;
		packet_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 49) == 0)
				calm = !calm;
			hold = calm ? 0 : $urandom_range(0, 11);
			if (hold != 0) begin
				packet_if.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			packet_if.ready <= 1'b1;
			@(posedge clk);
			while (!packet_if.valid) @(posedge clk);
		end
	end

	// compare each packet byte transfer with the oldest expectation
	always @(posedge clk) begin : packet_check
		pkt_beat_t want;
		pkt_beat_t got;
		if (arst_n && packet_if.valid && packet_if.ready) begin
			got = '{octet: packet_if.out_byte, pend: packet_if.packet_end,
				last: packet_if.run_last};
			if (due_bytes.size() == 0) begin
				log_mismatch("no byte due", '0, got);
			end else begin
				want = due_bytes[0];
				due_bytes.delete(0);
				if (got.octet !== want.octet || got.pend !== want.pend ||
						got.last !== want.last)
					log_mismatch("wrong byte", want, got);
			end
		end
	end

	initial begin
		#100_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		cfg_t        c;
		int          i;
		int unsigned phase;
		int unsigned counted;
		int unsigned pick;
		int unsigned sent;
		logic [LEN_W-1:0]  len;
		logic [KIND_W-1:0] kind;

		arst_n                <= 1'b0;
		frame_if.valid        <= 1'b0;
		frame_if.data_byte    <= '0;
		frame_if.frame_start  <= 1'b0;
		frame_if.frame_kind   <= '0;
		frame_if.frame_length <= '0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset settings first and then stream mode extremes
		for (i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_SPLIT) begin
				wait_drain();
				set_config(STREAM_EXTREMES);
			end
			send_byte(dir_rows[i].beat, dir_rows[i].n_typed, dir_rows[i].typed);
		end

		// random phases, each under its own settings
		for (phase = 0; phase < PHASES; phase++) begin
			wait_drain();
			c.udp_mode   = 1'($urandom);
			c.frame_rate = RATE_W'($urandom);
			c.ssrc_value = $urandom;
			case (phase)
				0: begin
					c.udp_mode   = 1'b1;
					c.frame_rate = 8'd1;
					c.ssrc_value = '0;
				end
				1: begin
					c.udp_mode   = 1'b0;
					c.frame_rate = 8'd29;
				end
				2: begin
					c.udp_mode   = 1'b1;
					c.frame_rate = RATE_LIMIT;
					c.ssrc_value = '1;
				end
				3: begin
					c.udp_mode   = 1'b0;
					c.frame_rate = 8'hFF;
				end
				default: ;
			endcase
			set_config(c);

			// in the first four phases, a frame at or above the chunk size, cut short after its first few bytes
			case (phase)
				0: send_frame(1'b1, KIND_I, LEN_W'($urandom_range(1401, 1410)), LEAD_BYTES);
				1: begin
					len = LEN_W'($urandom_range(1401, MAX_FRAME));
					send_frame(1'b1, KIND_P, len, LEAD_BYTES);
				end
				2: send_frame(1'b1, KIND_I, LEN_W'(MAX_PAYLOAD), LEAD_BYTES);
				3: send_frame(1'b1, KIND_P, LEN_W'(2 * MAX_PAYLOAD), LEAD_BYTES);
				default: ;
			endcase

			counted = 0;
			while (counted < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					// well-formed frame, now and then cut short
					kind = ($urandom_range(0, 2) == 0) ? KIND_I : KIND_P;
					len  = LEN_W'($urandom_range(1, 12));
					sent = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
					send_frame(1'b1, kind, len, sent);
					counted += sent;
				end else if (pick < 85) begin
					kind = ($urandom_range(0, 1) == 0) ? KIND_B : KIND_OTHER;
					len  = LEN_W'($urandom_range(1, 8));
					send_frame(1'b1, kind, len, len);
				end else if (pick < 93) begin
					len = ($urandom_range(0, 1) == 0) ? '0 :
						LEN_W'($urandom_range(MAX_FRAME + 1, LEN_TOP));
					send_frame(1'b1, KIND_W'($urandom), len, $urandom_range(1, 3));
				end else begin
					send_frame(1'b0, KIND_I, '0, $urandom_range(1, 3));
				end
			end
		end

		wait_drain();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[filelist.f]
design/rvp_pkg.sv
design/rvp_byte_if.sv
design/rvp_pkt_if.sv
design/rvp_cfg_regs.sv
design/rvp_frame_ctrl.sv
design/rvp_emitter.sv
design/rtp_video_packetizer.sv
sim/tb_top.sv
